// ===== rtl/core/shuffled_lehmer_random_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Shuffled Lehmer generator assertion macros
// Concurrent check helpers clocked by i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_LEHMER_RANDOM_GENERATOR_DEFINES_SVH
`define SHUFFLED_LEHMER_RANDOM_GENERATOR_DEFINES_SVH

// Same-cycle implication.
`define SLR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slr check failed");

// Next-cycle implication.
`define SLR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slr check failed");

`endif

// ===== rtl/core/slr_pkg.sv =====
// ----------------------------------------------------------------------------
// Shuffled Lehmer generator package
// Shared widths, constants, command codes and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int VAL_W       = 31;
    localparam int THR_W       = 20;

    // Park-Miller minimal standard generator
    localparam int MUL_W  = 15;
    localparam int PROD_W = VAL_W + MUL_W;
    localparam logic [MUL_W-1:0] LEH_MUL = MUL_W'(16807);
    localparam logic [VAL_W-1:0] LEH_MOD = VAL_W'(32'h7FFF_FFFF);
    localparam longint LEH_DIV   = 1 + (longint'(32'h7FFF_FFFF) - 1) / TABLE_DEPTH;
    localparam int     IDX_SHIFT = $clog2(LEH_DIV);

    // Warm-up: eight discarded steps, then one step per table entry
    localparam int WARM_STEPS = TABLE_DEPTH + 8;
    localparam int STEP_W     = $clog2(WARM_STEPS);

    // Percent trial: remainder by 1000000 through a reciprocal
    localparam int TRIAL_SHIFT = 51;
    localparam int RECIP_W     = 32;
    localparam int QP_W        = VAL_W + RECIP_W;
    localparam int Q_W         = QP_W - TRIAL_SHIFT;
    localparam int REM_W       = 21;
    localparam logic [RECIP_W-1:0] TRIAL_RECIP = RECIP_W'(64'd2251799813);
    localparam logic [THR_W-1:0]   TRIAL_MOD   = THR_W'(1000000);

    typedef enum logic [1:0] {
        CMD_RESEED = 2'd0,
        CMD_DRAW   = 2'd1,
        CMD_TRIAL  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic hit;
    } t_trial_res;

    // Zero and the modulus itself would lock the generator; map them to one.
    function automatic logic [VAL_W-1:0] seed_fix(input logic [VAL_W-1:0] v);
        seed_fix = ((v == '0) || (v == LEH_MOD)) ? VAL_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/slr_ram.sv =====
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slr_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/slr_lehmer.sv =====
// ----------------------------------------------------------------------------
// Lehmer step unit
// Multiply by 16807, register, then fold modulo 2^31-1 in the next cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slr_lehmer import slr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_start,
    input  logic [VAL_W-1:0] i_x,
    output logic [VAL_W-1:0] o_y
);

    logic [PROD_W-1:0] n_prod;
    logic [PROD_W-1:0] r_prod;
    logic [VAL_W:0]    w_sum;

    assign n_prod = PROD_W'(i_x) * PROD_W'(LEH_MUL);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= n_prod;
        end
    end

    // 2^31 == 1 mod (2^31-1): add the high part into the low part
    assign w_sum = (VAL_W+1)'(r_prod[VAL_W-1:0]) + (VAL_W+1)'(r_prod[PROD_W-1:VAL_W]);
    assign o_y   = (w_sum >= (VAL_W+1)'(LEH_MOD)) ? VAL_W'(w_sum - (VAL_W+1)'(LEH_MOD))
                                                   : w_sum[VAL_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/slr_trial.sv =====
// ----------------------------------------------------------------------------
// Percent trial pipeline
// Three-stage remainder by 1000000 and compare against the threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slr_trial import slr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAL_W-1:0] i_value,
    input  logic [THR_W-1:0] i_threshold,
    output t_trial_res       o_res
);

    logic [2:0]         r_vld;
    logic [VAL_W-1:0]   r_v1;
    logic [VAL_W-1:0]   r_v2;
    logic [THR_W-1:0]   r_thr1;
    logic [THR_W-1:0]   r_thr2;
    logic [THR_W-1:0]   r_thr3;
    logic [QP_W-1:0]    r_qp;
    logic [VAL_W:0]     r_qd;
    logic [REM_W-1:0]   r_rem;
    logic [Q_W-1:0]     w_q;
    logic [VAL_W:0]     w_diff;
    logic [REM_W-1:0]   w_rem_fix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
    end

    // Quotient estimate is exact or one low
    assign w_q    = r_qp[QP_W-1:TRIAL_SHIFT];
    assign w_diff = (VAL_W+1)'(r_v2) - r_qd;

    always_ff @(posedge i_clk) begin
        r_v1   <= i_value;
        r_thr1 <= i_threshold;
        r_qp   <= QP_W'(i_value) * QP_W'(TRIAL_RECIP);
        r_v2   <= r_v1;
        r_thr2 <= r_thr1;
        r_qd   <= (VAL_W+1)'(w_q) * (VAL_W+1)'(TRIAL_MOD);
        r_thr3 <= r_thr2;
        r_rem  <= w_diff[REM_W-1:0];
    end

    assign w_rem_fix = (r_rem >= REM_W'(TRIAL_MOD)) ? REM_W'(r_rem - REM_W'(TRIAL_MOD)) : r_rem;

    assign o_res.valid = r_vld[2];
    assign o_res.hit   = (w_rem_fix < REM_W'(r_thr3));

endmodule

`default_nettype wire

// ===== rtl/core/shuffled_lehmer_random_generator.sv =====
// ----------------------------------------------------------------------------
// Shuffled Lehmer random generator
// Park-Miller multiplier (16807 mod 2^31-1) behind a Bays-Durham shuffle
// table held in a synchronous RAM, with a percent-trial comparator.
// ----------------------------------------------------------------------------
//  channel | handshake                     | payload
//  --------+-------------------------------+------------------------------------
//  cfg     | i_cfg_we                      | i_cfg_wdata (seed)
//  in      | i_in_valid / o_in_ready       | i_command, i_threshold
//  out     | o_out_valid / i_out_ready     | o_random_value, o_trial_hit
//
//  A raw draw steps through accept, multiply plus table read, fold plus
//  table write and output load; a trial adds the remainder pipeline.
//  The first draw after reset or reseed first runs 40 warm-up steps of the
//  multiply/fold loop. Reseed and the unused code finish on acceptance.
//  Reset is synchronous, active low; the table needs no clearing pass.
//  A stalled output holds the finished result in the output stage until
//  its transfer; the next item is taken once the core is back in idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "shuffled_lehmer_random_generator_defines.svh"

module shuffled_lehmer_random_generator import slr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [VAL_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_command,
    input  logic [THR_W-1:0] i_threshold,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [VAL_W-1:0] o_random_value,
    output logic             o_trial_hit
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_WARM_MUL  = 7'b0000010,
        S_WARM_FOLD = 7'b0000100,
        S_DRAW_MUL  = 7'b0001000,
        S_DRAW_FOLD = 7'b0010000,
        S_TRIAL     = 7'b0100000,
        S_DONE      = 7'b1000000
    } t_state;

    t_state             r_state;
    logic [VAL_W-1:0]   r_seed;
    logic [VAL_W-1:0]   r_gen;      // generator value
    logic [VAL_W-1:0]   r_last;     // previous output, picks the table entry
    logic               r_init;     // table refill pending
    logic [STEP_W-1:0]  r_step;     // warm-up countdown
    t_cmd               r_cmd;
    logic [THR_W-1:0]   r_thr;
    logic [VAL_W-1:0]   r_res;
    logic               r_hit;
    logic               r_o_valid;
    logic [VAL_W-1:0]   r_o_value;
    logic               r_o_hit;

    logic               w_in_xfer;
    t_cmd               w_cmd;
    logic               w_need_init;
    logic [VAL_W-1:0]   w_init_gen;
    logic               w_lstart;
    logic [VAL_W-1:0]   w_ly;
    logic [IDX_W-1:0]   w_idx;
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [VAL_W-1:0]   w_rdata;
    logic [VAL_W-1:0]   w_draw_out;
    logic               w_tstart;
    t_trial_res         w_trial;
    logic               w_o_load;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_cmd       = t_cmd'(i_command);

    // Refill on pending reseed, or from one if the previous output is zero
    assign w_need_init = r_init || (r_last == '0);
    assign w_init_gen  = seed_fix(r_init ? r_gen : VAL_W'(1));

    // Top bits of the previous output select the entry
    assign w_idx       = IDX_W'(r_last >> IDX_SHIFT);

    // Every step multiplies the current generator value
    assign w_lstart    = (r_state == S_WARM_MUL) || (r_state == S_DRAW_MUL);

    // Warm-up fills entries from the top down during its last steps;
    // a draw swaps the fresh generator value into the picked entry.
    assign w_we    = ((r_state == S_WARM_FOLD) && (r_step < STEP_W'(TABLE_DEPTH)))
                  || (r_state == S_DRAW_FOLD);
    assign w_waddr = (r_state == S_WARM_FOLD) ? r_step[IDX_W-1:0] : w_idx;

    assign w_draw_out = (w_rdata == LEH_MOD) ? VAL_W'(LEH_MOD - VAL_W'(1)) : w_rdata;
    assign w_tstart   = (r_state == S_DRAW_FOLD) && (r_cmd == CMD_TRIAL);

    // Load the finished result once the output stage is free
    assign w_o_load   = (r_state == S_DONE) && (!r_o_valid || i_out_ready);

    slr_lehmer u_lehmer (
        .i_clk   (i_clk),
        .i_start (w_lstart),
        .i_x     (r_gen),
        .o_y     (w_ly)
    );

    slr_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VAL_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_ly),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    slr_trial u_trial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_tstart),
        .i_value     (w_draw_out),
        .i_threshold (r_thr),
        .o_res       (w_trial)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_seed    <= VAL_W'(1);
            r_gen     <= VAL_W'(1);
            r_last    <= '0;
            r_init    <= 1'b1;
            r_step    <= '0;
            r_cmd     <= CMD_NONE;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            // load a finished result, or drop the output once its transfer completes
            if (w_o_load) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_cmd <= w_cmd;
                        r_thr <= i_threshold;
                        unique case (w_cmd)
                            CMD_RESEED: begin
                                r_gen  <= seed_fix(r_seed);
                                r_init <= 1'b1;
                            end
                            CMD_DRAW, CMD_TRIAL: begin
                                if (w_need_init) begin
                                    r_gen   <= w_init_gen;
                                    r_step  <= STEP_W'(WARM_STEPS - 1);
                                    r_state <= S_WARM_MUL;
                                end else begin
                                    r_state <= S_DRAW_MUL;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_WARM_MUL: begin
                    r_state <= S_WARM_FOLD;
                end
                S_WARM_FOLD: begin
                    r_gen <= w_ly;
                    if (r_step == '0) begin
                        // entry zero was just written with this value
                        r_last  <= w_ly;
                        r_init  <= 1'b0;
                        r_state <= S_DRAW_MUL;
                    end else begin
                        r_step  <= r_step - STEP_W'(1);
                        r_state <= S_WARM_MUL;
                    end
                end
                S_DRAW_MUL: begin
                    r_state <= S_DRAW_FOLD;
                end
                S_DRAW_FOLD: begin
                    r_gen   <= w_ly;
                    r_last  <= w_draw_out;
                    r_res   <= w_draw_out;
                    r_hit   <= 1'b0;
                    r_state <= (r_cmd == CMD_TRIAL) ? S_TRIAL : S_DONE;
                end
                S_TRIAL: begin
                    if (w_trial.valid) begin
                        r_hit   <= w_trial.hit;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output stage is free
                    if (w_o_load) begin
                        r_o_value <= r_res;
                        r_o_hit   <= r_hit;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_random_value = r_o_value;
    assign o_trial_hit    = r_o_hit;

    // The generator never collapses to zero
    `SLR_ASSERT_IMP(a_gen_nonzero, 1'b1, r_gen != '0)
    // Output values stay below the modulus
    `SLR_ASSERT_IMP(a_out_range, o_out_valid, o_random_value != LEH_MOD)
    // Trial result lines up with the wait state
    `SLR_ASSERT_IMP(a_trial_align, w_trial.valid, r_state == S_TRIAL)
    // Finishing the warm-up clears the refill request
    `SLR_ASSERT_NXT(a_warm_done, (r_state == S_WARM_FOLD) && (r_step == '0), !r_init)

endmodule

`default_nettype wire
